@@ design/streaming_conv1d_top_defines.svh @@
// ----------------------------------------------------------------------------
// streaming_conv1d_top_defines
// assertion macros shared by the convolution block, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef STREAMING_CONV1D_TOP_DEFINES_SVH
`define STREAMING_CONV1D_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SC1D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sc1d assertion failed");
// next-cycle implication
`define SC1D_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sc1d assertion failed");
`else
`define SC1D_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SC1D_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/sc1d_pkg.sv @@
// ----------------------------------------------------------------------------
// sc1d_pkg
// shared field widths, codes and control structs of the 1-d convolution
// ----------------------------------------------------------------------------
package sc1d_pkg;

	localparam int KIND_W     = 2;
	localparam int INDEX_W    = 11;
	localparam int VALUE_W    = 16;
	localparam int OUT_CH_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_WEIGHT = 2'd1,
		KIND_BIAS   = 2'd2
	} kind_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_CH  = 2'd0,
		CFG_OUT_CH = 2'd1,
		CFG_KERNEL = 2'd2,
		CFG_STRIDE = 2'd3
	} cfg_idx_t;

	// one term issued to the multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic first;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
	} mac_status_t;

endpackage

@@ design/sc1d_intf.sv @@
// ----------------------------------------------------------------------------
// sc1d_intf
// valid/ready channels of the convolution block: items, results, config
// ----------------------------------------------------------------------------
interface sc1d_feed_if;
	logic                                valid;
	logic                                ready;
	logic [sc1d_pkg::KIND_W-1:0]         kind;
	logic [sc1d_pkg::INDEX_W-1:0]        index;
	logic signed [sc1d_pkg::VALUE_W-1:0] value;

	modport source (output valid, kind, index, value, input ready);
	modport sink (input valid, kind, index, value, output ready);
endinterface

interface sc1d_result_if;
	logic                                valid;
	logic                                ready;
	logic [sc1d_pkg::OUT_CH_W-1:0]       channel;
	logic signed [sc1d_pkg::VALUE_W-1:0] out_value;
	logic                                saturated;
	logic                                last;

	modport source (output valid, channel, out_value, saturated, last, input ready);
	modport sink (input valid, channel, out_value, saturated, last, output ready);
endinterface

interface sc1d_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sc1d_pkg::CFG_IDX_W-1:0]     index;
	logic [sc1d_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/sc1d_ram.sv @@
// ----------------------------------------------------------------------------
// sc1d_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module sc1d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/sc1d_mac.sv @@
// ----------------------------------------------------------------------------
// sc1d_mac
// shared multiply-accumulate unit with round-to-nearest and saturation
// ----------------------------------------------------------------------------
module sc1d_mac #(
	parameter int ACC_W = 41
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sc1d_pkg::mac_ctl_t                 ctl,
	input  logic signed [sc1d_pkg::VALUE_W-1:0] sample,
	input  logic signed [sc1d_pkg::VALUE_W-1:0] weight,
	input  logic signed [sc1d_pkg::VALUE_W-1:0] bias,
	output sc1d_pkg::mac_status_t              status,
	output logic signed [sc1d_pkg::VALUE_W-1:0] res_value,
	output logic                               res_sat
);

	import sc1d_pkg::*;

	localparam int RW = ACC_W - 12;
	localparam logic signed [RW-1:0] R_MAX = RW'(32767);
	localparam logic signed [RW-1:0] R_MIN = RW'(-32768);

	mac_ctl_t                    ctl_s1;
	mac_ctl_t                    ctl_s2;
	logic signed [2*VALUE_W-1:0] prod_s2;
	logic signed [VALUE_W-1:0]   bias_s2;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [ACC_W-1:0]     rnd_sum;
	logic signed [RW-1:0]        rnd;

	// operands arrive from the memories in the cycle after ctl
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= sample * weight;
		bias_s2 <= bias;
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_q <= (ACC_W'(bias_s2) <<< 12) + ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// ties away from zero: add 2047 on negative sums, 2048 otherwise
	assign rnd_sum = acc_q + (acc_q[ACC_W-1] ? ACC_W'(2047) : ACC_W'(2048));
	assign rnd     = RW'(rnd_sum >>> 12);

	always_comb begin
		res_sat   = 1'b0;
		res_value = VALUE_W'(rnd);
		if (rnd > R_MAX) begin
			res_sat   = 1'b1;
			res_value = 16'sh7fff;
		end else if (rnd < R_MIN) begin
			res_sat   = 1'b1;
			res_value = 16'sh8000;
		end
	end

	assign status.busy = ctl_s1.valid | ctl_s2.valid;

endmodule

@@ design/streaming_conv1d_top.sv @@
// ----------------------------------------------------------------------------
// streaming_conv1d_top
// strided multichannel 1-d convolution over a stream of token elements
// ----------------------------------------------------------------------------
// load items and samples that do not finish a window leave the sequencer in ST_IDLE;
// a firing sample issues in_count * kernel_length terms per output channel in ST_MAC,
// one term per cycle through the shared unit, then passes ST_DRAIN and ST_EMIT, which
// waits while a result is not taken; results leave one per output channel, the last
// waiting in the output register; after reset a clearing pass zeroes every entry of
// the window memory while no item is taken; config writes are always taken
`include "streaming_conv1d_top_defines.svh"

module streaming_conv1d_top #(
	parameter int MAX_IN_CHANNELS  = 16,
	parameter int MAX_OUT_CHANNELS = 16,
	parameter int MAX_KERNEL       = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	sc1d_feed_if.sink     feed,
	sc1d_result_if.source result,
	sc1d_cfg_if.sink      cfg
);

	import sc1d_pkg::*;

	// address and count widths
	localparam int CH_W        = MAX_IN_CHANNELS > 1 ? $clog2(MAX_IN_CHANNELS) : 1;
	localparam int SLOT_W      = MAX_KERNEL > 1 ? $clog2(MAX_KERNEL) : 1;
	localparam int WIN_AW      = CH_W + SLOT_W;
	localparam int WIN_DEPTH   = 1 << WIN_AW;
	localparam int NI_W        = $clog2(MAX_IN_CHANNELS + 1);
	localparam int NO_W        = $clog2(MAX_OUT_CHANNELS + 1);
	localparam int KL_W        = $clog2(MAX_KERNEL + 1);
	localparam int SC_W        = KL_W + 1;
	localparam int W_FULL      = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL;
	localparam int W_DEPTH     = W_FULL < (1 << INDEX_W) ? W_FULL : (1 << INDEX_W);
	localparam int W_AW        = W_DEPTH > 1 ? $clog2(W_DEPTH) : 1;
	localparam int B_AW        = MAX_OUT_CHANNELS > 1 ? $clog2(MAX_OUT_CHANNELS) : 1;
	localparam int POS_W       = (KL_W + 1) > 5 ? (KL_W + 1) : 5;
	localparam int ACC_W       = 33 + $clog2(MAX_IN_CHANNELS * MAX_KERNEL + 1);
	localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(MAX_KERNEL);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// configuration registers
	logic [4:0] cfg_nin_q;
	logic [4:0] cfg_nout_q;
	logic [3:0] cfg_klen_q;
	logic [3:0] cfg_stride_q;

	// sequencer state
	state_t                  state_q;
	logic [WIN_AW-1:0]       clr_q;
	logic [SLOT_W-1:0]       newest_q;
	logic signed [POS_W-1:0] pos_q;
	logic [NO_W-1:0]         o_q;
	logic [NI_W-1:0]         i_q;
	logic [KL_W-1:0]         k_q;
	logic [W_AW-1:0]         w_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [SLOT_W-1:0]       base_q;

	// output register
	logic                    out_valid_q;
	logic [OUT_CH_W-1:0]     out_ch_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                    out_sat_q;
	logic                    out_last_q;

	// effective counts after clamping
	logic [NI_W-1:0]         nin_eff;
	logic [NO_W-1:0]         nout_eff;
	logic [KL_W-1:0]         klen_eff;
	logic [3:0]              stride_eff;
	logic signed [POS_W-1:0] klen_s;
	logic signed [POS_W-1:0] stride_s;
	logic signed [POS_W-1:0] pos_inc;

	// item decode
	logic                    feed_acc;
	logic                    is_sample;
	logic                    idx_ok;
	logic                    tok_end;
	logic                    fire;
	logic [SC_W-1:0]         slot_inc;
	logic [SLOT_W-1:0]       next_slot;
	logic [SC_W-1:0]         next_ext;
	logic [SC_W-1:0]         klm1_ext;
	logic [SC_W-1:0]         base_full;
	logic [SC_W-1:0]         scan_inc;
	logic [SLOT_W-1:0]       scan_next;
	logic                    last_k;
	logic                    last_i;
	logic                    out_free;

	// memory ports
	logic                    win_we;
	logic [WIN_AW-1:0]       win_waddr;
	logic [VALUE_W-1:0]      win_wdata;
	logic [VALUE_W-1:0]      win_rdata;
	logic                    wgt_we;
	logic [VALUE_W-1:0]      wgt_rdata;
	logic                    bias_we;
	logic [VALUE_W-1:0]      bias_rdata;

	// mac unit
	mac_ctl_t                mac_ctl;
	mac_status_t             mac_status;
	logic signed [VALUE_W-1:0] mac_value;
	logic                    mac_sat;

	// ------------------------------------------------------------------
	// configuration port, always ready
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_nin_q    <= 5'd1;
			cfg_nout_q   <= 5'd1;
			cfg_klen_q   <= 4'd1;
			cfg_stride_q <= 4'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_IN_CH:  cfg_nin_q    <= cfg.data;
				CFG_OUT_CH: cfg_nout_q   <= cfg.data;
				CFG_KERNEL: cfg_klen_q   <= cfg.data[3:0];
				CFG_STRIDE: cfg_stride_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything above the maximum acts as the maximum
	always_comb begin
		nin_eff = NI_W'(cfg_nin_q);
		if (cfg_nin_q == 5'd0) begin
			nin_eff = NI_W'(1);
		end else if (32'(cfg_nin_q) > 32'(MAX_IN_CHANNELS)) begin
			nin_eff = NI_W'(MAX_IN_CHANNELS);
		end
		nout_eff = NO_W'(cfg_nout_q);
		if (cfg_nout_q == 5'd0) begin
			nout_eff = NO_W'(1);
		end else if (32'(cfg_nout_q) > 32'(MAX_OUT_CHANNELS)) begin
			nout_eff = NO_W'(MAX_OUT_CHANNELS);
		end
		klen_eff = KL_W'(cfg_klen_q);
		if (cfg_klen_q == 4'd0) begin
			klen_eff = KL_W'(1);
		end else if (32'(cfg_klen_q) > 32'(MAX_KERNEL)) begin
			klen_eff = KL_W'(MAX_KERNEL);
		end
		stride_eff = (cfg_stride_q == 4'd0) ? 4'd1 : cfg_stride_q;
	end

	assign klen_s   = POS_W'(klen_eff);
	assign stride_s = POS_W'(stride_eff);
	assign pos_inc  = pos_q + POS_W'(1);

	// ------------------------------------------------------------------
	// item decode
	// ------------------------------------------------------------------
	assign feed.ready = (state_q == ST_IDLE);
	assign feed_acc   = feed.valid && feed.ready;
	assign is_sample  = (feed.kind == KIND_SAMPLE);
	assign idx_ok     = 32'(feed.index) < 32'(nin_eff);
	assign tok_end    = 32'(feed.index) == (32'(nin_eff) - 32'd1);

	// ring slot that the token being built goes to
	assign slot_inc  = SC_W'(newest_q) + SC_W'(1);
	assign next_slot = (32'(slot_inc) >= 32'(MAX_KERNEL)) ? '0 : slot_inc[SLOT_W-1:0];

	// oldest slot of the window once the token in next_slot completes
	assign next_ext  = SC_W'(next_slot);
	assign klm1_ext  = SC_W'(klen_eff) - SC_W'(1);
	assign base_full = (next_ext >= klm1_ext) ? (next_ext - klm1_ext)
		: (next_ext + SC_W'(MAX_KERNEL) - klm1_ext);

	// a completed token fires when the window holds kernel_length tokens
	assign fire = feed_acc && is_sample && idx_ok && tok_end
		&& !pos_q[POS_W-1] && (pos_inc >= klen_s);

	// tap scan through the ring
	assign scan_inc  = SC_W'(slot_q) + SC_W'(1);
	assign scan_next = (32'(scan_inc) >= 32'(MAX_KERNEL)) ? '0 : scan_inc[SLOT_W-1:0];
	assign last_k    = (k_q == klen_eff - KL_W'(1));
	assign last_i    = (i_q == nin_eff - NI_W'(1));

	assign out_free  = !out_valid_q || result.ready;

	// ------------------------------------------------------------------
	// memories
	// ------------------------------------------------------------------
	// clearing pass owns the write port right after reset
	assign win_we    = (state_q == ST_CLEAR) || (feed_acc && is_sample && idx_ok);
	assign win_waddr = (state_q == ST_CLEAR) ? clr_q : {next_slot, feed.index[CH_W-1:0]};
	assign win_wdata = (state_q == ST_CLEAR) ? '0 : feed.value;

	assign wgt_we  = feed_acc && (feed.kind == KIND_WEIGHT) && (32'(feed.index) < 32'(W_FULL));
	assign bias_we = feed_acc && (feed.kind == KIND_BIAS)
		&& (32'(feed.index) < 32'(MAX_OUT_CHANNELS));

	sc1d_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (WIN_DEPTH)
	) u_window_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (win_waddr),
		.wdata (win_wdata),
		.raddr ({slot_q, i_q[CH_W-1:0]}),
		.rdata (win_rdata)
	);

	sc1d_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (W_DEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (feed.index[W_AW-1:0]),
		.wdata (feed.value),
		.raddr (w_q),
		.rdata (wgt_rdata)
	);

	sc1d_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_OUT_CHANNELS)
	) u_bias_ram (
		.clk   (clk),
		.we    (bias_we),
		.waddr (feed.index[B_AW-1:0]),
		.wdata (feed.value),
		.raddr (o_q[B_AW-1:0]),
		.rdata (bias_rdata)
	);

	// ------------------------------------------------------------------
	// multiply-accumulate unit, one term per cycle in ST_MAC
	// ------------------------------------------------------------------
	assign mac_ctl.valid = (state_q == ST_MAC);
	assign mac_ctl.first = (i_q == '0) && (k_q == '0);

	sc1d_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.sample    ($signed(win_rdata)),
		.weight    ($signed(wgt_rdata)),
		.bias      ($signed(bias_rdata)),
		.status    (mac_status),
		.res_value (mac_value),
		.res_sat   (mac_sat)
	);

	// ------------------------------------------------------------------
	// sequencer and output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			newest_q    <= '0;
			pos_q       <= '0;
			o_q         <= '0;
			i_q         <= '0;
			k_q         <= '0;
			w_q         <= '0;
			slot_q      <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
			out_ch_q    <= '0;
			out_value_q <= '0;
			out_sat_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			// in ST_EMIT the output register is refilled below instead
			if (out_valid_q && result.ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + WIN_AW'(1);
					if (clr_q == WIN_AW'(WIN_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (feed_acc && is_sample && idx_ok && tok_end) begin
						if (pos_q[POS_W-1]) begin
							// token being skipped over by the stride
							pos_q <= pos_inc;
						end else begin
							newest_q <= next_slot;
							if (fire) begin
								pos_q   <= klen_s - stride_s;
								o_q     <= '0;
								i_q     <= '0;
								k_q     <= '0;
								w_q     <= '0;
								base_q  <= base_full[SLOT_W-1:0];
								slot_q  <= base_full[SLOT_W-1:0];
								state_q <= ST_MAC;
							end else begin
								pos_q <= pos_inc;
							end
						end
					end
				end
				ST_MAC: begin
					// weight address runs straight through the (out, in, tap) layout
					w_q <= w_q + W_AW'(1);
					if (last_k) begin
						k_q    <= '0;
						slot_q <= base_q;
						if (last_i) begin
							i_q     <= '0;
							state_q <= ST_DRAIN;
						end else begin
							i_q <= i_q + NI_W'(1);
						end
					end else begin
						k_q    <= k_q + KL_W'(1);
						slot_q <= scan_next;
					end
				end
				ST_DRAIN: begin
					if (!mac_status.busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_ch_q    <= OUT_CH_W'(o_q);
						out_value_q <= mac_value;
						out_sat_q   <= mac_sat;
						out_last_q  <= (o_q == nout_eff - NO_W'(1));
						if (o_q == nout_eff - NO_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							o_q     <= o_q + NO_W'(1);
							state_q <= ST_MAC;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid     = out_valid_q;
	assign result.channel   = out_ch_q;
	assign result.out_value = out_value_q;
	assign result.saturated = out_sat_q;
	assign result.last      = out_last_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// rounding only ever sees a fully drained accumulator
	`SC1D_ASSERT_IMP(a_emit_drained, clk, arst_n, state_q == ST_EMIT, !mac_status.busy)
	// the output channel counter stays inside the configured range while working
	`SC1D_ASSERT_IMP(a_out_range, clk, arst_n, state_q == ST_MAC, o_q < nout_eff)
	// a firing token always starts the tap scan
	`SC1D_ASSERT_NXT(a_fire_starts, clk, arst_n, fire, state_q == ST_MAC)
	// window position never runs past the largest kernel
	`SC1D_ASSERT_IMP(a_pos_bound, clk, arst_n, state_q == ST_IDLE, pos_q <= POS_MAX)

endmodule
